### hdl/longest_prefix_match_table_assert.svh
// assertion macros for the prefix table checker
`ifndef LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH

// same-cycle implication
`define LPMT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prefix table check failed");

// next-cycle implication
`define LPMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prefix table check failed");

`endif

### hdl/lpmt_pkg.sv
// types and constants shared by the prefix table modules
`default_nettype none

package lpmt_pkg;

   localparam int ADDR_BITS   = 32;
   localparam int LEN_W       = 6;
   localparam int ROUTER_BITS = 16;
   localparam int STATUS_W    = 2;

   localparam logic [ADDR_BITS-1:0] ADDR_ONES = {ADDR_BITS{1'b1}};

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic                   opcode;
      logic [ADDR_BITS-1:0]   address_bits;
      logic [LEN_W-1:0]       address_length;
      logic [ROUTER_BITS-1:0] router_number;
   } lpmt_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ROUTER_BITS-1:0] selected_router;
      logic [LEN_W-1:0]       match_length;
   } lpmt_rsp_type;

   // transaction as it travels along the row of entry cells
   typedef struct packed {
      logic                   opcode;
      logic [ADDR_BITS-1:0]   bits;       // masked to the length
      logic [ADDR_BITS-1:0]   mask;       // leading-bit mask of the length
      logic [LEN_W-1:0]       len;        // saturated length
      logic [ROUTER_BITS-1:0] router;
      logic                   done;       // insert placed, or lookup matched
      logic [LEN_W-1:0]       res_len;
      logic [ROUTER_BITS-1:0] res_router;
   } lpmt_item_type;

endpackage

`default_nettype wire

### hdl/lpmt_cell.sv
// one table entry with its stage of the transaction row
`default_nettype none

module lpmt_cell
   import lpmt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire lpmt_item_type in_item,
   output logic               out_valid,
   output lpmt_item_type      out_item
);

   logic                   entry_valid_ff;
   logic                   entry_valid_in;
   logic [ADDR_BITS-1:0]   entry_prefix_ff;
   logic [ADDR_BITS-1:0]   entry_prefix_in;
   logic [ADDR_BITS-1:0]   entry_mask_ff;
   logic [ADDR_BITS-1:0]   entry_mask_in;
   logic [LEN_W-1:0]       entry_length_ff;
   logic [LEN_W-1:0]       entry_length_in;
   logic [ROUTER_BITS-1:0] entry_router_ff;
   logic [ROUTER_BITS-1:0] entry_router_in;
   logic                   out_valid_ff;
   lpmt_item_type          out_item_ff;
   lpmt_item_type          out_item_in;
   logic                   take;
   logic                   same_prefix;
   logic                   covers;

   assign take = advance && in_valid;

   assign same_prefix = entry_valid_ff && (entry_length_ff == in_item.len)
                        && (entry_prefix_ff == in_item.bits);
   assign covers = entry_valid_ff && (entry_length_ff <= in_item.len)
                   && ((in_item.bits & entry_mask_ff) == entry_prefix_ff);

   always_comb begin
      entry_valid_in  = entry_valid_ff;
      entry_prefix_in = entry_prefix_ff;
      entry_mask_in   = entry_mask_ff;
      entry_length_in = entry_length_ff;
      entry_router_in = entry_router_ff;
      out_item_in     = in_item;
      if (in_item.opcode == OP_INSERT) begin
         // entries fill from the head, so an empty cell ends the search
         if (!in_item.done && (same_prefix || !entry_valid_ff)) begin
            entry_valid_in   = 1'b1;
            entry_prefix_in  = in_item.bits;
            entry_mask_in    = in_item.mask;
            entry_length_in  = in_item.len;
            entry_router_in  = in_item.router;
            out_item_in.done = 1'b1;
         end
      end else begin
         if (covers && (!in_item.done || (entry_length_ff > in_item.res_len))) begin
            out_item_in.done       = 1'b1;
            out_item_in.res_len    = entry_length_ff;
            out_item_in.res_router = entry_router_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            entry_valid_ff <= entry_valid_in;
         end
         if (advance) begin
            out_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_prefix_ff <= entry_prefix_in;
         entry_mask_ff   <= entry_mask_in;
         entry_length_ff <= entry_length_in;
         entry_router_ff <= entry_router_in;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

`default_nettype wire

### hdl/longest_prefix_match_table.sv
// longest-prefix-match routing table, top level
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  lpmt_req_type: opcode, address, length, router
//   rsp      out        rsp_valid/rsp_stall  lpmt_rsp_type: status, router, match length
//
// one transaction enters per cycle unless req_stall is high
// each result passes through the row of entry cells, then the result register
// reset clears every entry's valid bit and all pipeline valids at once, no clearing pass
// a stalled result freezes the whole row, and req_stall follows it in the same cycle
`default_nettype none

module longest_prefix_match_table
   import lpmt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire lpmt_req_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output lpmt_rsp_type      rsp_payload
);

   // links between cells: link 0 feeds the head, the last link leaves the tail
   logic          link_valid [TABLE_ENTRIES+1];
   lpmt_item_type link_item  [TABLE_ENTRIES+1];

   logic             advance;
   logic [LEN_W-1:0] len_sat;
   logic [ADDR_BITS-1:0] lead_mask;
   lpmt_item_type    head_item;
   lpmt_item_type    tail_item;
   logic             rsp_valid_ff;
   lpmt_rsp_type     rsp_ff;
   lpmt_rsp_type     rsp_in;

   // the row moves whenever the result register is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // overlong lengths saturate to the address width
   assign len_sat = (req_payload.address_length > LEN_W'(ADDR_BITS)) ?
                    LEN_W'(ADDR_BITS) : req_payload.address_length;
   // shifting the all-ones word right by the length leaves the trailing bits
   assign lead_mask = ~(ADDR_ONES >> len_sat);

   always_comb begin
      head_item.opcode     = req_payload.opcode;
      head_item.bits       = req_payload.address_bits & lead_mask;
      head_item.mask       = lead_mask;
      head_item.len        = len_sat;
      head_item.router     = req_payload.router_number;
      head_item.done       = 1'b0;
      head_item.res_len    = '0;
      head_item.res_router = '0;
   end

   assign link_valid[0] = req_valid;
   assign link_item[0]  = head_item;

   // row of entry cells, each comparing against its own entry
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      lpmt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (link_valid[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_item  (link_item[g+1])
      );
   end

   assign tail_item = link_item[TABLE_ENTRIES];

   // result formatting at the tail of the row
   always_comb begin
      rsp_in.status          = ST_OK;
      rsp_in.selected_router = '0;
      rsp_in.match_length    = '0;
      if (tail_item.opcode == OP_INSERT) begin
         if (tail_item.done) begin
            rsp_in.selected_router = tail_item.router;
            rsp_in.match_length    = tail_item.len;
         end else begin
            // no equal prefix and no empty entry anywhere in the row
            rsp_in.status = ST_FULL;
         end
      end else begin
         if (tail_item.done) begin
            rsp_in.selected_router = tail_item.res_router;
            rsp_in.match_length    = tail_item.res_len;
         end else begin
            rsp_in.status = ST_NOMATCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= link_valid[TABLE_ENTRIES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### hdl/lpmt_checker.sv
// port-level checks for the prefix table and their binding to the top level
`default_nettype none

`include "longest_prefix_match_table_assert.svh"

module lpmt_checker
   import lpmt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire lpmt_req_type req_payload,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire lpmt_rsp_type rsp_payload
);

   logic req_seen;

   // an accepted request that is not seen anywhere would hide a dead port
   assign req_seen = req_valid && !req_stall && (req_payload.opcode == OP_INSERT
                     || req_payload.opcode == OP_LOOKUP);

   // a held result keeps its value
   `LPMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload))

   // requests are only held off by a waiting result
   `LPMT_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // failures carry no router and no length
   `LPMT_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && (rsp_payload.status != ST_OK),
      (rsp_payload.selected_router == '0) && (rsp_payload.match_length == '0))

   // reported lengths never exceed the address width
   `LPMT_ASSERT_SAME(a_len_range, clock, reset, rsp_valid || req_seen,
      !rsp_valid || (rsp_payload.match_length <= LEN_W'(ADDR_BITS)))

endmodule

bind longest_prefix_match_table lpmt_checker u_lpmt_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for the longest-prefix-match routing table
`timescale 1ns / 1ps

module tb_top;
   import lpmt_pkg::*;

   localparam int ROUTE_SLOTS  = 64;
   localparam int RANDOM_ITEMS = 1350;
   // the zero-length default route goes in late, so that misses stay possible for most of the run
   localparam int DEFAULT_ROUTE_AT = 1000;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   lpmt_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   lpmt_rsp_type rsp_payload;

   // transactions waiting to be sent, and results owed by the block in arrival order
   lpmt_req_type pending_requests[$];
   lpmt_rsp_type expected_replies[$];

   // the testbench's own copy of the routing table
   bit                     route_used[ROUTE_SLOTS];
   logic [ADDR_BITS-1:0]   route_prefix[ROUTE_SLOTS];
   int                     route_len[ROUTE_SLOTS];
   logic [ROUTER_BITS-1:0] route_router[ROUTE_SLOTS];

   // prefixes handed to the block so far, used to aim lookups and overwrites at stored entries
   logic [ADDR_BITS-1:0] known_bits[$];
   int                   known_len[$];

   int fault_count = 0;
   int send_wait   = 0;
   int take_wait   = 0;
   bit send_calm   = 1'b0;
   bit take_calm   = 1'b0;

   longest_prefix_match_table #(
      .TABLE_ENTRIES(ROUTE_SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // keeps the leading len bits of an address
   function automatic logic [ADDR_BITS-1:0] lead_mask(input int len);
      if (len == 0) return '0;
      return ADDR_ONES << (ADDR_BITS - len);
   endfunction

   // applies one transaction to the local table and returns the result the block must give
   function automatic lpmt_rsp_type route_table_step(input lpmt_req_type t);
      lpmt_rsp_type           r;
      int                     len;
      logic [ADDR_BITS-1:0]   bits;
      int                     hit;
      int                     spare;
      bit                     found;
      int                     best_len;
      logic [ROUTER_BITS-1:0] best_router;
      r = '0;
      // overlong lengths saturate, bits past the length are dropped
      len  = (int'(t.address_length) > ADDR_BITS) ? ADDR_BITS : int'(t.address_length);
      bits = t.address_bits & lead_mask(len);
      if (t.opcode == OP_INSERT) begin
         hit   = -1;
         spare = -1;
         for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (route_used[s]) begin
               if (hit < 0 && route_len[s] == len && route_prefix[s] == bits) hit = s;
            end else if (spare < 0) begin
               spare = s;
            end
         end
         // an existing prefix is overwritten in place, otherwise the lowest free slot
         if (hit < 0) hit = spare;
         if (hit < 0) begin
            r.status = ST_FULL;
         end else begin
            route_used[hit]   = 1'b1;
            route_prefix[hit] = bits;
            route_len[hit]    = len;
            route_router[hit] = t.router_number;
            r.status          = ST_OK;
            r.selected_router = t.router_number;
            r.match_length    = len[LEN_W-1:0];
         end
      end else begin
         found       = 1'b0;
         best_len    = 0;
         best_router = '0;
         // only stored prefixes no longer than the query can match
         for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (route_used[s] && route_len[s] <= len &&
                (bits & lead_mask(route_len[s])) == route_prefix[s] &&
                (!found || route_len[s] > best_len)) begin
               found       = 1'b1;
               best_len    = route_len[s];
               best_router = route_router[s];
            end
         end
         if (found) begin
            r.status          = ST_OK;
            r.selected_router = best_router;
            r.match_length    = best_len[LEN_W-1:0];
         end else begin
            r.status = ST_NOMATCH;
         end
      end
      return r;
   endfunction

   // per-transaction idle draw; a calm stretch gives back-to-back traffic
   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic push_request(input logic op, input logic [ADDR_BITS-1:0] addr,
                               input int len, input logic [ROUTER_BITS-1:0] router);
      lpmt_req_type t;
      t.opcode         = op;
      t.address_bits   = addr;
      t.address_length = len[LEN_W-1:0];
      t.router_number  = router;
      pending_requests = {pending_requests, t};
   endtask

   // inserts that also feed the pool of prefixes for later lookups
   task automatic push_route(input logic [ADDR_BITS-1:0] addr, input int len,
                             input logic [ROUTER_BITS-1:0] router);
      push_request(OP_INSERT, addr, len, router);
      known_bits = {known_bits, addr};
      known_len  = {known_len, ((len > ADDR_BITS) ? ADDR_BITS : len)};
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         fault_count++;
      end
   endtask

   // driver: offers the queued transactions, holding each one while the block stalls
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // accepted transactions go straight through the local table, in order
         if (req_valid && !req_stall) begin
            expected_replies = {expected_replies, route_table_step(req_payload)};
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_payload <= pending_requests.pop_front();
               req_valid   <= 1'b1;
               send_wait   <= draw_wait(send_calm);
               if ($urandom_range(0, 29) == 0) send_calm <= !send_calm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result against the oldest owed one, then stalls for a random spell
   always @(posedge clock) begin : take_side
      int           next_wait;
      lpmt_rsp_type want;
      next_wait = take_wait;
      if (reset) begin
         next_wait = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: result with nothing outstanding, actual %0h", $time, rsp_payload);
            fault_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_payload.status));
            check_field("selected_router", 32'(want.selected_router),
                        32'(rsp_payload.selected_router));
            check_field("match_length", 32'(want.match_length),
                        32'(rsp_payload.match_length));
         end
         next_wait = draw_wait(take_calm);
         if ($urandom_range(0, 29) == 0) take_calm <= !take_calm;
      end else if (take_wait > 0) begin
         next_wait = take_wait - 1;
      end
      take_wait <= next_wait;
      rsp_stall <= (next_wait != 0);
   end

   // stimulus and end of run
   initial begin : stimulus
      int                     roll;
      int                     k;
      int                     plen;
      int                     qlen;
      logic [ADDR_BITS-1:0]   addr;
      logic [ADDR_BITS-1:0]   m;
      logic [ROUTER_BITS-1:0] router;

      // empty table: every lookup misses, including one with a saturating length
      push_request(OP_LOOKUP, 32'h0000_0000, 0, 16'h0000);
      push_request(OP_LOOKUP, 32'hFFFF_FFFF, 63, 16'hFFFF);
      // full-length host route, then the same route with an overlong length overwrites it
      push_route(32'hFFFF_FFFF, 32, 16'hFFFF);
      push_route(32'hFFFF_FFFF, 63, 16'h0000);
      // nested prefixes, the first with stray bits past its length
      push_route(32'hC0A8_5A5A, 16, 16'h1234);
      push_route(32'hC0A8_0100, 24, 16'hBEEF);
      push_request(OP_LOOKUP, 32'hC0A8_0105, 32, 16'hFFFF);
      push_request(OP_LOOKUP, 32'hC0A8_FF00, 32, 16'h0000);
      // query shorter than the longer prefix, which must not count
      push_request(OP_LOOKUP, 32'hC0A8_0100, 20, 16'h0000);
      push_request(OP_LOOKUP, 32'hC0A8_0000, 8, 16'h0000);
      push_route(32'h8000_0000, 1, 16'h0001);
      push_request(OP_LOOKUP, 32'hFFFF_FFFF, 32, 16'h0000);
      push_request(OP_LOOKUP, 32'hFFFF_FFFF, 31, 16'h0000);
      push_request(OP_LOOKUP, 32'h7FFF_FFFF, 32, 16'h0000);
      // overwrite with different stray bits past the length
      push_route(32'hC0A8_FFFF, 16, 16'hFFFF);
      push_request(OP_LOOKUP, 32'hC0A8_0000, 16, 16'h0000);
      push_request(OP_LOOKUP, 32'h0000_0000, 40, 16'h0000);
      push_route(32'h0000_0000, 32, 16'h0000);
      push_request(OP_LOOKUP, 32'h0000_0000, 33, 16'hFFFF);

      // random part: mostly lookups aimed at stored prefixes; new prefixes arrive slowly,
      // so the table fills about halfway through and table-full answers follow
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll   = $urandom_range(0, 99);
         router = 16'($urandom_range(0, 65535));
         k      = $urandom_range(0, known_bits.size() - 1);
         if (n == DEFAULT_ROUTE_AT) begin
            push_route($urandom, 0, router);
         end else if (roll < 35) begin
            if ($urandom_range(0, 9) < 3) begin
               // new prefix, often nested under or over a known one
               if ($urandom_range(0, 1) == 1) begin
                  plen = $urandom_range(1, 32);
                  m    = lead_mask(plen);
                  addr = (known_bits[k] & m) | ($urandom & ~m);
               end else begin
                  plen = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 32)
                                                     : $urandom_range(1, 16);
                  addr = $urandom;
               end
               if (plen == ADDR_BITS && $urandom_range(0, 1) == 1) plen = $urandom_range(33, 63);
               push_route(addr, plen, router);
            end else begin
               // overwrite of a known prefix with fresh stray bits
               plen = known_len[k];
               m    = lead_mask(plen);
               addr = (known_bits[k] & m) | ($urandom & ~m);
               if (plen == ADDR_BITS) plen = $urandom_range(32, 63);
               push_request(OP_INSERT, addr, plen, router);
            end
         end else begin
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
               // query that starts with a known prefix; sometimes cut shorter than it
               plen = known_len[k];
               m    = lead_mask(plen);
               addr = (known_bits[k] & m) | ($urandom & ~m);
               qlen = (roll < 5) ? $urandom_range(plen, 32) : $urandom_range(0, plen);
               if (qlen == ADDR_BITS) qlen = $urandom_range(32, 63);
               push_request(OP_LOOKUP, addr, qlen, router);
            end else begin
               push_request(OP_LOOKUP, $urandom, $urandom_range(0, 63), router);
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, every result back, then a quiet spell for stray results
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4 * ROUTE_SLOTS) @(posedge clock);
      if (fault_count == 0 && expected_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
